@@ rtl/core/chte_pkg.sv @@
// chte_pkg: shared types, codes and constants of the chained hash table engine.
// No dependencies.
package chte_pkg;

    localparam int MAX_BUCKETS_DEF  = 256;
    localparam int POOL_ENTRIES_DEF = 512;
    localparam int KEY_BYTES_DEF    = 8;
    localparam int HASH_SHIFT_LO    = 6;
    localparam int HASH_SHIFT_HI    = 16;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_GET     = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_REPLACE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [63:0] lookup_key;
        logic [63:0]        new_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_value;
        logic [9:0]  entry_count;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_DIV,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_WALK_RD,
        S_WALK_WAIT,
        S_ALLOC_RD,
        S_ALLOC_WAIT,
        S_INS_WR,
        S_REM_WR,
        S_REM_LINK,
        S_VAL_RD,
        S_VAL_WAIT,
        S_RESP
    } state_t;

endpackage

@@ rtl/core/chte_ram.sv @@
// chte_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module chte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/chained_hash_table_engine_core.sv @@
// Chained hash table engine: key/value store with separate chaining over a fixed entry pool.
// Depends on chte_pkg and chte_ram (bucket heads, keys, values, links).
//
// One command at a time: in_ready is high only while idle, and the engine accepts the next
// command as soon as the previous result has been taken (or while it is being taken).
// After acceptance a command hashes the key, one hash cycle per key byte (ending at the
// first zero byte or the last key byte), takes a bit-serial remainder of the 64-bit hash
// by bucket_count, and then an insert allocates an entry and writes it, while a lookup
// fetches the bucket head, visits the chain entry by entry and ends as a miss, a remove
// (which also relinks the predecessor when the entry is not the chain head), or a get or
// replace (which reads the stored value). The chain walk dominates for long chains.
// After reset the engine first clears the bucket head table, one entry per cycle, and
// accepts no command until every entry has been cleared.
module chained_hash_table_engine_core #(
    parameter int MAX_BUCKETS  = chte_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_ENTRIES = chte_pkg::POOL_ENTRIES_DEF,
    parameter int KEY_BYTES    = chte_pkg::KEY_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  chte_pkg::req_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output chte_pkg::rsp_t     out_data
);
    import chte_pkg::*;

    localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int LW  = $clog2(POOL_ENTRIES + 1);
    localparam int PW  = $clog2(POOL_ENTRIES);
    localparam int BCW = $clog2(MAX_BUCKETS + 1);
    localparam int KBW = $clog2(KEY_BYTES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

    state_t state_reg, state_next;

    logic [8:0]   bcount_reg;
    logic         clr_reg;
    logic [BW:0]  clr_idx_reg;
    logic [1:0]   cmd_reg;
    logic [63:0]  key_reg, val_reg;
    logic [63:0]  hash_reg;
    logic [KBW-1:0] byte_idx_reg;
    logic [6:0]   div_cnt_reg;
    logic [BCW-1:0] rem_reg;
    logic [BCW-1:0] div_n;
    logic [LW-1:0] cur_reg, prev_reg, free_reg, alloc_reg;
    logic [LW:0]  water_reg;
    logic [LW-1:0] held_reg;
    logic [9:0]   steps_reg;
    logic [1:0]   status_reg;
    logic [63:0]  found_reg;
    logic         out_valid_reg;

    // memory ports
    logic          k_we, v_we, l_we, h_we;
    logic [PW-1:0] k_wa, v_wa, l_wa, k_ra, v_ra, l_ra;
    logic [63:0]   k_wd, v_wd, k_rd, v_rd;
    logic [LW-1:0] l_wd, l_rd, h_wd, h_rd;
    logic [BW-1:0] h_wa, h_ra;

    chte_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_keys (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
    chte_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_vals (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
    chte_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_links (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    chte_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

    logic [BW-1:0] bucket;
    logic [7:0]    cur_byte;
    logic          hash_last;
    logic [BCW:0]  rem_shift;
    logic          in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign in_ready = (state_reg == S_IDLE) && !clr_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data.status      = status_reg;
    assign out_data.found_value = found_reg;
    assign out_data.entry_count = 10'(held_reg);

    always_comb
    begin
        if (bcount_reg == 9'd0)
        begin
            div_n = BCW'(1);
        end
        else if (32'(bcount_reg) > MAX_BUCKETS)
        begin
            div_n = BCW'(MAX_BUCKETS);
        end
        else
        begin
            div_n = BCW'(bcount_reg);
        end
    end

    assign bucket    = BW'(rem_reg);
    assign cur_byte  = key_reg[8*3'(byte_idx_reg) +: 8];
    assign hash_last = (32'(byte_idx_reg) >= KEY_BYTES - 1);
    assign rem_shift = {rem_reg, hash_reg[63]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (cur_byte == 8'd0 || hash_last)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == 7'd63)
                begin
                    state_next = (cmd_reg == CMD_INSERT) ? S_ALLOC_RD : S_HEAD_RD;
                end
            end
            S_ALLOC_RD:   state_next = S_ALLOC_WAIT;
            S_ALLOC_WAIT: state_next = S_INS_WR;
            S_INS_WR:     state_next = S_RESP;
            S_HEAD_RD:    state_next = S_HEAD_WAIT;
            S_HEAD_WAIT:  state_next = S_WALK_RD;
            S_WALK_RD:
            begin
                if (cur_reg >= NIL || 32'(steps_reg) >= POOL_ENTRIES)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT:
            begin
                if (k_rd == key_reg)
                begin
                    state_next = (cmd_reg == CMD_REMOVE) ? S_REM_WR : S_VAL_RD;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_REM_WR:     state_next = (prev_reg < NIL) ? S_REM_LINK : S_RESP;
            S_REM_LINK:   state_next = S_RESP;
            S_VAL_RD:     state_next = S_VAL_WAIT;
            S_VAL_WAIT:   state_next = S_RESP;
            S_RESP:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // bucket head table: clear pass after reset, then insert and remove updates
    assign h_ra = bucket;

    always_comb
    begin
        h_we = 1'b0;
        h_wa = bucket;
        h_wd = alloc_reg;
        if (clr_reg)
        begin
            h_we = 1'b1;
            h_wa = clr_idx_reg[BW-1:0];
            h_wd = NIL;
        end
        else if (state_reg == S_INS_WR)
        begin
            h_we = (alloc_reg < NIL);
        end
        else if (state_reg == S_REM_WR)
        begin
            h_we = (prev_reg >= NIL);
        end
    end

    // memory control
    always_comb
    begin
        k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
        k_wa = PW'(alloc_reg); v_wa = PW'(alloc_reg); l_wa = PW'(alloc_reg);
        k_wd = key_reg; v_wd = val_reg; l_wd = h_rd;
        k_ra = PW'(cur_reg); v_ra = PW'(cur_reg); l_ra = PW'(cur_reg);
        unique case (state_reg)
            S_ALLOC_RD:
            begin
                l_ra = PW'(free_reg);
            end
            S_INS_WR:
            begin
                if (alloc_reg < NIL)
                begin
                    k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
                end
            end
            S_REM_WR:
            begin
                // push onto the free list; a head match relinks the bucket head alongside
                l_we = 1'b1;
                l_wa = PW'(cur_reg);
                l_wd = free_reg;
            end
            S_REM_LINK:
            begin
                // bypass the removed entry from its predecessor
                l_we = 1'b1;
                l_wa = PW'(prev_reg);
                l_wd = alloc_reg;
            end
            S_VAL_WAIT:
            begin
                if (cmd_reg == CMD_REPLACE)
                begin
                    v_we = 1'b1;
                    v_wa = PW'(cur_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bcount_reg    <= 9'd256;
            clr_reg       <= 1'b1;
            clr_idx_reg   <= '0;
            free_reg      <= NIL;
            water_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            key_reg       <= '0;
            val_reg       <= '0;
            hash_reg      <= '0;
            byte_idx_reg  <= '0;
            div_cnt_reg   <= '0;
            rem_reg       <= '0;
            cur_reg       <= NIL;
            prev_reg      <= NIL;
            alloc_reg     <= NIL;
            steps_reg     <= '0;
            status_reg    <= ST_DONE;
            found_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                bcount_reg <= cfg_data;
            end
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (32'(clr_idx_reg) == MAX_BUCKETS - 1)
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cmd_reg      <= in_data.command;
                        key_reg      <= in_data.lookup_key;
                        val_reg      <= in_data.new_value;
                        hash_reg     <= '0;
                        byte_idx_reg <= '0;
                        status_reg   <= ST_DONE;
                        found_reg    <= '0;
                        steps_reg    <= '0;
                        prev_reg     <= NIL;
                    end
                end
                S_HASH:
                begin
                    if (cur_byte != 8'd0)
                    begin
                        hash_reg <= 64'(cur_byte) + (hash_reg << HASH_SHIFT_LO)
                                    + (hash_reg << HASH_SHIFT_HI) - hash_reg;
                    end
                    byte_idx_reg <= byte_idx_reg + 1'b1;
                    div_cnt_reg  <= '0;
                    rem_reg      <= '0;
                end
                S_DIV:
                begin
                    // restoring remainder, one bit per cycle
                    if (rem_shift >= {1'b0, div_n})
                    begin
                        rem_reg <= BCW'(rem_shift - {1'b0, div_n});
                    end
                    else
                    begin
                        rem_reg <= BCW'(rem_shift);
                    end
                    hash_reg    <= hash_reg << 1;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                S_ALLOC_RD:
                begin
                    if (free_reg < NIL)
                    begin
                        alloc_reg <= free_reg;
                    end
                    else if (32'(water_reg) < POOL_ENTRIES)
                    begin
                        alloc_reg <= LW'(water_reg);
                    end
                    else
                    begin
                        alloc_reg <= NIL;
                    end
                end
                S_ALLOC_WAIT:
                begin
                    if (free_reg < NIL)
                    begin
                        free_reg <= l_rd;
                    end
                    else if (alloc_reg < NIL)
                    begin
                        water_reg <= water_reg + 1'b1;
                    end
                end
                S_INS_WR:
                begin
                    if (alloc_reg < NIL)
                    begin
                        held_reg <= held_reg + 1'b1;
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                end
                S_HEAD_WAIT:
                begin
                    cur_reg <= h_rd;
                end
                S_WALK_RD:
                begin
                    if (cur_reg >= NIL || 32'(steps_reg) >= POOL_ENTRIES)
                    begin
                        status_reg <= ST_MISSING;
                    end
                end
                S_WALK_WAIT:
                begin
                    if (k_rd != key_reg)
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= l_rd;
                        steps_reg <= steps_reg + 1'b1;
                    end
                    else
                    begin
                        // hold link of matched entry for unlinking
                        alloc_reg <= l_rd;
                    end
                end
                S_REM_WR:
                begin
                    free_reg <= cur_reg;
                    if (held_reg != '0)
                    begin
                        held_reg <= held_reg - 1'b1;
                    end
                end
                S_VAL_WAIT:
                begin
                    found_reg <= v_rd;
                end
                S_RESP:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

@@ rtl/core/chte_checker.sv @@
// chte_checker: port-level assertions for the chained hash table engine core.
// Depends on chte_pkg; bound to chained_hash_table_engine_core.
module chte_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  logic           out_valid,
    input  logic           out_ready,
    input  chte_pkg::rsp_t out_data
);
    import chte_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second transaction while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("undefined status code");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_DONE |-> out_data.found_value == 64'd0)
        else $error("found_value nonzero on failure");
endmodule

bind chained_hash_table_engine_core chte_checker u_chte_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
